@@ src/set_assoc_lru_cache_sim_unit_defines.svh @@
// Assertion macros shared by the cache simulator RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SALC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/salc_pkg.sv @@
// Shared constants and types for the set-associative LRU cache simulator.
// No dependencies; imported by the lookup stage and the top level.
package salc_pkg;

  // Trace commands.
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_IGNORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd3;

  // Configuration register indexes and widths.
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

  // Result field widths.
  localparam int HITS_W  = 2;
  localparam int COUNT_W = 32;

  // Outcome of one set lookup.
  typedef struct packed {
    logic hit;
    logic evict;
  } look_res_t;

endpackage

@@ src/set_assoc_lru_cache_sim_unit.sv @@
// Top level of the set-associative LRU cache simulator: control, counters, config.
// Depends on salc_pkg, salc_set_ram, salc_way_lookup and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready  | command, address
//   out     | out       | out_valid / out_ready| hits_now, missed_now, evicted_now, totals
//
// The set row is read from the set memory at the accept edge, the ways are compared
// in the look state, and the victim is picked and the row written back in the pick
// state. A new item is taken the cycle after the write-back.
// Reset clears per-set live flags in flip-flops; there is no memory clearing pass.
// A result not yet taken holds the next item in its final cycle.
`include "set_assoc_lru_cache_sim_unit_defines.svh"

module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32,
  parameter int STAMP_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [salc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [salc_pkg::CMD_W-1:0]        command,
  input  logic [ADDR_BITS-1:0]              address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [salc_pkg::HITS_W-1:0]       hits_now,
  output logic                              missed_now,
  output logic                              evicted_now,
  output logic [salc_pkg::COUNT_W-1:0]      hit_total,
  output logic [salc_pkg::COUNT_W-1:0]      miss_total,
  output logic [salc_pkg::COUNT_W-1:0]      eviction_total
);

  import salc_pkg::*;

  localparam int SET_IW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SHIFT_W = (ADDR_BITS > SET_IW) ? ADDR_BITS : SET_IW;
  localparam int ENTRY_W = 1 + ADDR_BITS + STAMP_BITS;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int ROWS    = 1 << SET_IW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;

  logic [1:0]              state;
  logic [CMD_W-1:0]        cmd_r;
  logic [ADDR_BITS-1:0]    tag_r;
  logic [SET_IW-1:0]       set_r;
  logic                    live_r;
  logic [STAMP_BITS-1:0]   access_clock;
  logic [ROWS-1:0]         row_live;

  logic [SET_BITS_W-1:0]   sb_eff;
  logic [5:0]              ways_eff;
  logic [MAX_WAYS-1:0]     way_en;
  logic [SHIFT_W-1:0]      shifted;
  logic [SET_IW-1:0]       set_mask;
  logic [SET_IW-1:0]       set_idx;
  logic [5:0]              tag_shift;
  logic [ADDR_BITS-1:0]    tag_val;

  logic                    accept;
  logic                    pick_go;
  logic                    mem_we;
  logic [ROW_W-1:0]        row_rd;
  logic [ROW_W-1:0]        row_wr;
  look_res_t               res;

  logic [HITS_W-1:0]       hits_inc;
  logic                    miss_inc;
  logic                    evict_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= WAYS_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits    <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_in_use <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp set bits and associativity to what the hardware holds.
  always_comb begin
    if ({1'b0, set_bits} > 5'(MAX_SET_BITS)) begin
      sb_eff = SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb_eff = set_bits;
    end
    if (ways_in_use == '0) begin
      ways_eff = 6'd1;
    end else if ({2'b00, ways_in_use} > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end else begin
      ways_eff = {2'b00, ways_in_use};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = 6'(w) < ways_eff;
    end
  end

  // Split the address into set index and tag.
  always_comb begin
    shifted   = SHIFT_W'(address) >> block_bits;
    set_mask  = ~({SET_IW{1'b1}} << sb_eff);
    set_idx   = shifted[SET_IW-1:0] & set_mask;
    tag_shift = {1'b0, block_bits} + {2'b00, sb_eff};
    tag_val   = address >> tag_shift;
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign pick_go  = (state == ST_PICK) & (~out_valid | out_ready);
  assign mem_we   = pick_go & (cmd_r != CMD_IGNORE);

  salc_set_ram #(
    .ADDR_W (SET_IW),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_idx),
    .rd_data (row_rd),
    .wr_en   (mem_we),
    .wr_addr (set_r),
    .wr_data (row_wr)
  );

  salc_way_lookup #(
    .WAYS    (MAX_WAYS),
    .TAG_W   (ADDR_BITS),
    .STAMP_W (STAMP_BITS)
  ) u_lookup (
    .clk      (clk),
    .look     (state == ST_LOOK),
    .row_live (live_r),
    .row_rd   (row_rd),
    .tag      (tag_r),
    .stamp    (access_clock),
    .way_en   (way_en),
    .res      (res),
    .row_wr   (row_wr)
  );

  // Per-item counts; the second access of a modify always hits.
  always_comb begin
    case (cmd_r)
      CMD_LOAD, CMD_STORE: hits_inc = res.hit ? HITS_W'(1) : HITS_W'(0);
      CMD_MODIFY:          hits_inc = res.hit ? HITS_W'(2) : HITS_W'(1);
      default:             hits_inc = HITS_W'(0);
    endcase
    miss_inc  = (cmd_r != CMD_IGNORE) & ~res.hit;
    evict_inc = (cmd_r != CMD_IGNORE) & res.evict;
  end

  // Sequencer, access clock, set live flags and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      access_clock   <= '0;
      row_live       <= '0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            access_clock <= access_clock + STAMP_BITS'(1);
            state        <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_PICK;
        end
        ST_PICK: begin
          if (pick_go) begin
            hit_total      <= hit_total + COUNT_W'(hits_inc);
            miss_total     <= miss_total + COUNT_W'(miss_inc);
            eviction_total <= eviction_total + COUNT_W'(evict_inc);
            if (cmd_r != CMD_IGNORE) begin
              row_live[set_r] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item fields held for the duration of the lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= command;
      tag_r  <= tag_val;
      set_r  <= set_idx;
      live_r <= row_live[set_idx];
    end
  end

  // Output register: loaded when the pick completes, held until the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pick_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_go) begin
      hits_now    <= hits_inc;
      missed_now  <= miss_inc;
      evicted_now <= evict_inc;
    end
  end

  // Checks on the sequencer and the result hold.
  `SALC_ASSERT_NEXT(a_accept_to_look, clk, rst, accept, state == ST_LOOK, "accept did not start a lookup")
  `SALC_ASSERT_SAME(a_write_in_pick, clk, rst, mem_we, state == ST_PICK, "set write outside the pick cycle")
  `SALC_ASSERT_NEXT(a_totals_hold, clk, rst, out_valid && !out_ready, $stable(hit_total) && $stable(miss_total), "totals moved while a result was held")
  `SALC_ASSERT_SAME(a_result_from_pick, clk, rst, $rose(out_valid), $past(state) == ST_PICK, "result appeared without a pick")

endmodule

@@ src/salc_set_ram.sv @@
// Synchronous set memory: one write port, one read port, registered read data.
// No dependencies.
module salc_set_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 520
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/salc_way_lookup.sv @@
// Way search for one set: tag match, first free way and oldest-stamp victim.
// Depends on salc_pkg for the lookup result type.
module salc_way_lookup #(
  parameter int WAYS    = 8,
  parameter int TAG_W   = 32,
  parameter int STAMP_W = 32
) (
  input  logic                                clk,
  input  logic                                look,
  input  logic                                row_live,
  input  logic [WAYS*(1+TAG_W+STAMP_W)-1:0]   row_rd,
  input  logic [TAG_W-1:0]                    tag,
  input  logic [STAMP_W-1:0]                  stamp,
  input  logic [WAYS-1:0]                     way_en,
  output salc_pkg::look_res_t                 res,
  output logic [WAYS*(1+TAG_W+STAMP_W)-1:0]   row_wr
);

  localparam int ENTRY_W = 1 + TAG_W + STAMP_W;

  logic [WAYS-1:0]    way_valid;
  logic [WAYS-1:0]    way_match;
  logic [WAYS-1:0]    way_cand;
  logic [WAYS-1:0]    way_empty;
  logic [TAG_W-1:0]   way_tag [WAYS];
  logic [STAMP_W-1:0] way_stamp [WAYS];
  logic [WAYS-1:0]    beats [WAYS];

  logic [WAYS-1:0]    match_q;
  logic [WAYS-1:0]    cand_q;
  logic [WAYS-1:0]    empty_q;
  logic [WAYS-1:0]    beats_q [WAYS];

  logic [WAYS-1:0]    hit_one;
  logic [WAYS-1:0]    empty_one;
  logic [WAYS-1:0]    victim;
  logic [WAYS-1:0]    wr_sel;

  // Unpack the row; a row never written since reset holds no valid ways.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = row_live & row_rd[w*ENTRY_W + ENTRY_W - 1];
      way_tag[w]   = row_rd[w*ENTRY_W + STAMP_W +: TAG_W];
      way_stamp[w] = row_rd[w*ENTRY_W +: STAMP_W];
      way_match[w] = way_valid[w] & way_en[w] & (way_tag[w] == tag);
      way_cand[w]  = way_valid[w] & way_en[w] & ~way_match[w];
      way_empty[w] = ~way_valid[w] & way_en[w];
    end
  end

  // Pairwise age order: way i beats way j if its stamp is smaller, or equal
  // with the lower way number. All compares are independent of each other.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      for (int j = 0; j < WAYS; j++) begin
        if (i == j) begin
          beats[i][j] = 1'b1;
        end else begin
          beats[i][j] = (way_stamp[i] < way_stamp[j]) ||
                        ((way_stamp[i] == way_stamp[j]) && (i < j));
        end
      end
    end
  end

  // First stage registers.
  always_ff @(posedge clk) begin
    if (look) begin
      match_q <= way_match;
      cand_q  <= way_cand;
      empty_q <= way_empty;
      for (int i = 0; i < WAYS; i++) begin
        beats_q[i] <= beats[i];
      end
    end
  end

  // Second stage: pick the way to write.
  always_comb begin
    hit_one   = match_q & (~match_q + WAYS'(1));
    empty_one = empty_q & (~empty_q + WAYS'(1));
    for (int i = 0; i < WAYS; i++) begin
      victim[i] = cand_q[i] & (&(beats_q[i] | ~cand_q));
    end
    if (|match_q) begin
      wr_sel = hit_one;
    end else if (|empty_q) begin
      wr_sel = empty_one;
    end else begin
      wr_sel = victim;
    end
    res.hit   = |match_q;
    res.evict = ~(|match_q) & ~(|empty_q);
  end

  // Write-back row: the chosen way takes the new tag and stamp.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (wr_sel[w]) begin
        row_wr[w*ENTRY_W +: ENTRY_W] = {1'b1, tag, stamp};
      end else begin
        row_wr[w*ENTRY_W +: ENTRY_W] = {way_valid[w], way_tag[w], way_stamp[w]};
      end
    end
  end

endmodule
